>>> sv/rskb_pkg.sv
// Package for the render sort key builder: field widths, codes and transfer types.
package rskb_pkg;

    localparam int POS_W      = 32;
    localparam int DIR_W      = 16;
    localparam int FAR_W      = 31;
    localparam int FRAC_SHIFT = 14;
    localparam int PROD_W     = POS_W + DIR_W;
    localparam int NUM_W      = PROD_W + 2;
    localparam int REM_W      = PROD_W;
    localparam int MAT_IN_W   = 16;
    localparam int STATE_IN_W = 24;
    localparam int KEY_W      = 64;
    localparam int LIST_W     = 2;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [LIST_W-1:0] LIST_OPAQUE  = 2'd0;
    localparam logic [LIST_W-1:0] LIST_BLENDED = 2'd1;
    localparam logic [LIST_W-1:0] LIST_BOTH    = 2'd2;

    typedef enum logic [1:0] {
        REG_VIEW_DIR_X    = 2'd0,
        REG_VIEW_DIR_Y    = 2'd1,
        REG_VIEW_DIR_Z    = 2'd2,
        REG_FAR_DISTANCE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    is_drawable;
        logic                    has_material;
        logic [MAT_IN_W-1:0]     material_id;
        logic [STATE_IN_W-1:0]   state_set_id;
        logic                    alpha_blend;
    } drawable_t;

    typedef struct packed {
        logic [KEY_W-1:0]  sort_key;
        logic [LIST_W-1:0] target_list;
    } key_t;

endpackage

>>> sv/render_sort_key_builder.sv
// Render sort key builder: pipelined depth quantiser and key packer.
//
// Usage: one drawable enters on the drawable channel (drawable_valid,
// drawable_stall, drawable) and one sort key with its target list leaves
// on the key channel (key_valid, key_stall, key) for each transfer in.
// Camera direction and far distance sit in an APB register file; the user
// must write them only while the block is idle, which the block does not enforce.
// Throughput is one drawable per cycle while key_stall does not hold the pipeline.
// A result passes one multiply stage, two add stages, one range compare
// stage, one restoring divide stage per depth bit and the output register.
// Reset clears all valid bits and loads the default camera registers; no
// clearing pass is needed, so a drawable may be sent in the first cycle
// after reset.
// While the receiver holds key_stall with a key pending, the whole pipeline
// holds and drawable_stall is raised; nothing is lost or repeated. Bubbles
// in the pipeline are not squeezed out during a stall.
module render_sort_key_builder
    import rskb_pkg::*;
#(
    parameter int DEPTH_BITS    = 24,
    parameter int MATERIAL_BITS = 16,
    parameter int STATE_BITS    = 24
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               drawable_valid,
    output logic               drawable_stall,
    input  drawable_t          drawable,

    output logic               key_valid,
    input  logic               key_stall,
    output key_t               key,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int FULL_W = STATE_BITS + MATERIAL_BITS + DEPTH_BITS;

    typedef struct packed {
        logic                     drawable;
        logic                     blend;
        logic [MATERIAL_BITS-1:0] mat;
        logic [STATE_BITS-1:0]    state;
    } side_t;

    typedef struct packed {
        logic                  sat_lo;
        logic                  sat_hi;
        logic [REM_W-1:0]      rem;
        logic [DEPTH_BITS-1:0] q;
    } div_t;

    logic signed [DIR_W-1:0] dir_x_reg;
    logic signed [DIR_W-1:0] dir_y_reg;
    logic signed [DIR_W-1:0] dir_z_reg;
    logic [FAR_W-1:0]        far_reg;
    logic [REM_W-1:0]        den_reg;

    logic                    advance;

    logic                     s1_valid_reg;
    side_t                    s1_side_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [PROD_W-1:0] prod_z_reg;

    logic                    s2_valid_reg;
    side_t                   s2_side_reg;
    logic signed [NUM_W-1:0] sum_xy_reg;
    logic signed [NUM_W-1:0] sum_zf_reg;

    logic                    s3_valid_reg;
    side_t                   s3_side_reg;
    logic signed [NUM_W-1:0] num_reg;

    logic                    div_valid_reg [DEPTH_BITS+1];
    side_t                   div_side_reg  [DEPTH_BITS+1];
    div_t                    div_reg       [DEPTH_BITS+1];
    div_t                    div_first_next;

    logic                    key_valid_reg;
    key_t                    key_reg;
    key_t                    key_next;
    logic [DEPTH_BITS-1:0]   depth;
    logic [FULL_W-1:0]       full_key;
    side_t                   side_first;
    div_t                    last;
    side_t                   last_side;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= DIR_W'(16384);
            far_reg   <= FAR_W'(65536);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_reg_t'(paddr[3:2]))
                REG_VIEW_DIR_X:   dir_x_reg <= pwdata[DIR_W-1:0];
                REG_VIEW_DIR_Y:   dir_y_reg <= pwdata[DIR_W-1:0];
                REG_VIEW_DIR_Z:   dir_z_reg <= pwdata[DIR_W-1:0];
                REG_FAR_DISTANCE: far_reg   <= pwdata[FAR_W-1:0];
                default:          far_reg   <= far_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[3:2]))
            REG_VIEW_DIR_X:   prdata = DATA_W'(dir_x_reg[DIR_W-1:0]);
            REG_VIEW_DIR_Y:   prdata = DATA_W'(dir_y_reg[DIR_W-1:0]);
            REG_VIEW_DIR_Z:   prdata = DATA_W'(dir_z_reg[DIR_W-1:0]);
            REG_FAR_DISTANCE: prdata = DATA_W'(far_reg);
            default:          prdata = '0;
        endcase
    end

    // three times far, aligned to the product format
    always_ff @(posedge clk)
    begin
        den_reg <= REM_W'({far_reg, {FRAC_SHIFT{1'b0}}})
                 + REM_W'({far_reg, {(FRAC_SHIFT + 1){1'b0}}});
    end

    // hold the pipeline while a finished key waits
    assign advance        = !(key_valid_reg && key_stall);
    assign drawable_stall = !advance;

    always_comb
    begin
        side_first.drawable = drawable.is_drawable;
        side_first.blend    = drawable.alpha_blend;
        side_first.mat      = drawable.has_material
                            ? MATERIAL_BITS'(drawable.material_id) : '0;
        side_first.state    = STATE_BITS'(drawable.state_set_id);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            key_valid_reg <= 1'b0;
            for (int i = 0; i <= DEPTH_BITS; i++)
            begin
                div_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s1_valid_reg     <= drawable_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            div_valid_reg[0] <= s3_valid_reg;
            for (int i = 0; i < DEPTH_BITS; i++)
            begin
                div_valid_reg[i+1] <= div_valid_reg[i];
            end
            key_valid_reg <= div_valid_reg[DEPTH_BITS];
        end
    end

    // multiply, sum, range check
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_side_reg <= side_first;
            prod_x_reg  <= drawable.pos_x * dir_x_reg;
            prod_y_reg  <= drawable.pos_y * dir_y_reg;
            prod_z_reg  <= drawable.pos_z * dir_z_reg;

            s2_side_reg <= s1_side_reg;
            sum_xy_reg  <= NUM_W'(prod_x_reg) + NUM_W'(prod_y_reg);
            sum_zf_reg  <= NUM_W'(prod_z_reg)
                         + NUM_W'($signed({1'b0, far_reg, {FRAC_SHIFT{1'b0}}}));

            s3_side_reg <= s2_side_reg;
            num_reg     <= sum_xy_reg + sum_zf_reg;

            div_side_reg[0] <= s3_side_reg;
            div_reg[0]      <= div_first_next;
        end
    end

    always_comb
    begin
        div_first_next.sat_lo = num_reg[NUM_W-1] || (num_reg == '0);
        div_first_next.sat_hi = !div_first_next.sat_lo
                              && (num_reg[NUM_W-2:0] >= (NUM_W-1)'(den_reg));
        div_first_next.rem    = num_reg[REM_W-1:0];
        div_first_next.q      = '0;
    end

    // one restoring divide step per stage
    for (genvar k = 0; k < DEPTH_BITS; k++)
    begin : g_div
        logic [REM_W-1:0] dbl;
        logic             ge;
        div_t             div_next;

        always_comb
        begin
            dbl          = {div_reg[k].rem[REM_W-2:0], 1'b0};
            ge           = dbl >= den_reg;
            div_next     = div_reg[k];
            div_next.rem = ge ? dbl - den_reg : dbl;
            div_next.q   = {div_reg[k].q[DEPTH_BITS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                div_reg[k+1]      <= div_next;
                div_side_reg[k+1] <= div_side_reg[k];
            end
        end
    end

    // saturate, invert for blending, pack
    assign last      = div_reg[DEPTH_BITS];
    assign last_side = div_side_reg[DEPTH_BITS];

    always_comb
    begin
        if (last.sat_lo)
        begin
            depth = '0;
        end
        else if (last.sat_hi)
        begin
            depth = '1;
        end
        else
        begin
            depth = last.q;
        end
        if (last_side.blend)
        begin
            depth = ~depth;
        end
        full_key = {last_side.state, last_side.mat, depth};
        if (!last_side.drawable)
        begin
            key_next.sort_key    = '0;
            key_next.target_list = LIST_BOTH;
        end
        else
        begin
            key_next.sort_key    = KEY_W'(full_key);
            key_next.target_list = last_side.blend ? LIST_BLENDED : LIST_OPAQUE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_next;
        end
    end

    assign key_valid = key_valid_reg;
    assign key       = key_reg;

`ifndef SYNTHESIS
    a_both_lists_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key.target_list == LIST_BOTH |-> key.sort_key == '0)
        else $error("key for both lists is not zero");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[0] && !div_reg[0].sat_lo && !div_reg[0].sat_hi
            |-> div_reg[0].rem < den_reg)
        else $error("divide start remainder not below denominator");

    a_sat_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        div_valid_reg[DEPTH_BITS] |-> !(last.sat_lo && last.sat_hi))
        else $error("depth saturated both low and high");

    a_list_code: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid |-> key.target_list == LIST_OPAQUE
            || key.target_list == LIST_BLENDED || key.target_list == LIST_BOTH)
        else $error("target list code out of range");
`endif

endmodule
